// ===== src/pkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pkd_pkg;

   localparam int DEF_SAMPLE_BITS   = 16;
   localparam int DEF_POSITION_BITS = 20;
   // twice the trapezoid area, saturating two's complement
   localparam int AREA_BITS         = 38;

   // control of the item held in the input register
   typedef struct packed {
      logic valid;
      logic start_record;
   } item_ctrl_type;

endpackage

`default_nettype wire

// ===== src/pkd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkd_in_reg #(
   parameter int SAMPLE_BITS = pkd_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_start,
   input  wire logic                          advance,
   output pkd_pkg::item_ctrl_type             item,
   output logic signed [SAMPLE_BITS-1:0]      item_sample
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          start_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          accept;

   // the held item leaves in the same cycle a new one arrives
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         start_ff  <= req_start;
         sample_ff <= req_sample;
      end
   end

   assign item.valid        = valid_ff;
   assign item.start_record = start_ff;
   assign item_sample       = sample_ff;

endmodule

`default_nettype wire

// ===== src/pkd_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkd_tracker #(
   parameter int SAMPLE_BITS   = pkd_pkg::DEF_SAMPLE_BITS,
   parameter int POSITION_BITS = pkd_pkg::DEF_POSITION_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] csr_data,
   input  wire pkd_pkg::item_ctrl_type        item,
   input  wire logic signed [SAMPLE_BITS-1:0] item_sample,
   input  wire logic                          advance,
   output logic                               emit,
   output logic [POSITION_BITS-1:0]           left_pos,
   output logic signed [SAMPLE_BITS-1:0]      left_level,
   output logic [POSITION_BITS-1:0]           top_pos,
   output logic signed [SAMPLE_BITS-1:0]      top_level,
   output logic [POSITION_BITS-1:0]           right_pos,
   output logic signed [SAMPLE_BITS-1:0]      right_level,
   output logic signed [pkd_pkg::AREA_BITS-1:0] area_doubled
);

   localparam int A = pkd_pkg::AREA_BITS;
   localparam logic signed [A+1:0] AREA_MAX = (A+2)'({1'b0, {(A-1){1'b1}}});
   localparam logic signed [A+1:0] AREA_MIN = -AREA_MAX - (A+2)'(1);

   logic signed [SAMPLE_BITS-1:0]   threshold_ff;

   logic [POSITION_BITS-1:0]        position_ff, position_in;
   logic                            left_found_ff, left_found_in;
   logic [POSITION_BITS-1:0]        left_at_ff, left_at_in;
   logic signed [SAMPLE_BITS-1:0]   left_val_ff, left_val_in;
   logic                            top_found_ff, top_found_in;
   logic [POSITION_BITS-1:0]        top_at_ff, top_at_in;
   logic signed [SAMPLE_BITS-1:0]   top_val_ff, top_val_in;
   logic                            right_found_ff, right_found_in;
   logic [POSITION_BITS-1:0]        right_at_ff, right_at_in;
   logic signed [SAMPLE_BITS-1:0]   right_val_ff, right_val_in;
   logic signed [SAMPLE_BITS-1:0]   prior_ff, prior_in;
   logic signed [A-1:0]             area_ff, area_in;

   // state as seen by this sample: a record start wipes it first
   logic                            e_left_found, e_top_found, e_right_found;
   logic [POSITION_BITS-1:0]        x;
   logic signed [SAMPLE_BITS-1:0]   e_prior, e_top_val;
   logic signed [A-1:0]             e_area;
   logic signed [A+1:0]             sum_wide;
   logic signed [A-1:0]             area_sat;
   logic                            low;
   logic                            step;

   assign step = item.valid && advance;

   always_comb begin
      e_left_found  = item.start_record ? 1'b0 : left_found_ff;
      e_top_found   = item.start_record ? 1'b0 : top_found_ff;
      e_right_found = item.start_record ? 1'b0 : right_found_ff;
      e_top_val     = item.start_record ? '0 : top_val_ff;
      e_prior       = item.start_record ? '0 : prior_ff;
      e_area        = item.start_record ? '0 : area_ff;
      x             = item.start_record ? '0 : position_ff;

      sum_wide = (A+2)'(e_area) + (A+2)'(item_sample) + (A+2)'(e_prior);
      if (sum_wide > AREA_MAX) begin
         area_sat = A'(AREA_MAX);
      end else if (sum_wide < AREA_MIN) begin
         area_sat = A'(AREA_MIN);
      end else begin
         area_sat = A'(sum_wide);
      end

      low = item_sample < threshold_ff;

      left_found_in  = e_left_found;
      left_at_in     = item.start_record ? '0 : left_at_ff;
      left_val_in    = item.start_record ? '0 : left_val_ff;
      top_found_in   = e_top_found;
      top_at_in      = item.start_record ? '0 : top_at_ff;
      top_val_in     = e_top_val;
      right_found_in = e_right_found;
      right_at_in    = item.start_record ? '0 : right_at_ff;
      right_val_in   = item.start_record ? '0 : right_val_ff;
      area_in        = e_area;
      emit           = 1'b0;

      if (low) begin
         if (e_right_found) begin
            // second low sample after the peak: report and drop the peak
            emit           = 1'b1;
            left_found_in  = 1'b0;
            left_at_in     = '0;
            left_val_in    = '0;
            top_found_in   = 1'b0;
            top_at_in      = '0;
            top_val_in     = '0;
            right_found_in = 1'b0;
            right_at_in    = '0;
            right_val_in   = '0;
            area_in        = '0;
         end else if (x == '0) begin
            // first sample of a record is never a trough
         end else if (e_left_found && e_top_found) begin
            area_in        = area_sat;
            right_found_in = 1'b1;
            right_at_in    = x;
            right_val_in   = item_sample;
         end else begin
            left_found_in = 1'b1;
            left_at_in    = x;
            left_val_in   = item_sample;
            area_in       = '0;
         end
      end else if (e_left_found) begin
         if (!e_right_found) begin
            area_in = area_sat;
         end
         if (!e_top_found || item_sample >= e_top_val) begin
            top_found_in = 1'b1;
            top_at_in    = x;
            top_val_in   = item_sample;
         end
      end

      prior_in    = item_sample;
      position_in = x + POSITION_BITS'(1);
   end

   // the result comes from the state before this sample is applied
   assign left_pos     = left_at_ff;
   assign left_level   = left_val_ff;
   assign top_pos      = top_at_ff;
   assign top_level    = top_val_ff;
   assign right_pos    = right_at_ff;
   assign right_level  = right_val_ff;
   assign area_doubled = area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= '0;
         position_ff    <= '0;
         left_found_ff  <= 1'b0;
         left_at_ff     <= '0;
         left_val_ff    <= '0;
         top_found_ff   <= 1'b0;
         top_at_ff      <= '0;
         top_val_ff     <= '0;
         right_found_ff <= 1'b0;
         right_at_ff    <= '0;
         right_val_ff   <= '0;
         prior_ff       <= '0;
         area_ff        <= '0;
      end else begin
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
         if (step) begin
            position_ff    <= position_in;
            left_found_ff  <= left_found_in;
            left_at_ff     <= left_at_in;
            left_val_ff    <= left_val_in;
            top_found_ff   <= top_found_in;
            top_at_ff      <= top_at_in;
            top_val_ff     <= top_val_in;
            right_found_ff <= right_found_in;
            right_at_ff    <= right_at_in;
            right_val_ff   <= right_val_in;
            prior_ff       <= prior_in;
            area_ff        <= area_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/pkd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkd_out_reg #(
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [DATA_BITS-1:0] load_data,
   output logic                      ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DATA_BITS-1:0]      rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [DATA_BITS-1:0] data_ff;

   // free when empty or when the held result goes out this cycle
   assign ready = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== src/threshold_peak_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Threshold peak detector. Signed samples stream in with a record-start flag
// in tuser; each is compared with the threshold written on the csr port. A
// peak is reported as left trough, maximum and right trough with twice the
// trapezoid area between the troughs, saturated to 38 bits. One sample can be
// taken every cycle. A result is valid on the rsp port after the sample that
// triggers it is accepted: the sample sits in the input register, the tracker
// state updates in a single compare-add-select step, and the result register
// then loads once it is free. A result held by a stalled receiver holds back
// the input. Write the threshold only while no samples are in flight.
module threshold_peak_detector #(
   parameter int SAMPLE_BITS   = pkd_pkg::DEF_SAMPLE_BITS,
   parameter int POSITION_BITS = pkd_pkg::DEF_POSITION_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [SAMPLE_BITS-1:0]   csr_data,     // threshold
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,    // sample
   input  wire logic                     req_tuser,    // start_record
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // left_pos, left_level, top_pos, top_level, right_pos, right_level, area_doubled
   output logic [((3 * POSITION_BITS + 3 * SAMPLE_BITS + pkd_pkg::AREA_BITS + 7) / 8) * 8 - 1:0]
                                         rsp_tdata
);

   localparam int RES_BITS  = 3 * POSITION_BITS + 3 * SAMPLE_BITS + pkd_pkg::AREA_BITS;
   localparam int RSP_BITS  = ((RES_BITS + 7) / 8) * 8;

   pkd_pkg::item_ctrl_type              item;
   logic signed [SAMPLE_BITS-1:0]       item_sample;
   logic                                out_ready;
   logic                                emit;
   logic [POSITION_BITS-1:0]            left_pos, top_pos, right_pos;
   logic signed [SAMPLE_BITS-1:0]       left_level, top_level, right_level;
   logic signed [pkd_pkg::AREA_BITS-1:0] area_doubled;
   logic [RES_BITS-1:0]                 result;
   logic [RES_BITS-1:0]                 rsp_result;

   assign csr_ready = 1'b1;

   pkd_in_reg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .req_start   (req_tuser),
      .advance     (out_ready),
      .item        (item),
      .item_sample (item_sample)
   );

   pkd_tracker #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .item         (item),
      .item_sample  (item_sample),
      .advance      (out_ready),
      .emit         (emit),
      .left_pos     (left_pos),
      .left_level   (left_level),
      .top_pos      (top_pos),
      .top_level    (top_level),
      .right_pos    (right_pos),
      .right_level  (right_level),
      .area_doubled (area_doubled)
   );

   assign result = {area_doubled, right_level, right_pos, top_level, top_pos,
                    left_level, left_pos};

   pkd_out_reg #(
      .DATA_BITS (RES_BITS)
   ) u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (item.valid && out_ready && emit),
      .load_data (result),
      .ready     (out_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_result)
   );

   assign rsp_tdata = RSP_BITS'(rsp_result);

   // input side stalls only behind a held item that cannot move on
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (item.valid && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked result");

   // troughs are never at the first position of a record
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result[POSITION_BITS-1:0] != '0 &&
         rsp_result[2*POSITION_BITS+2*SAMPLE_BITS +: POSITION_BITS] != '0))
      else $error("result reports a trough at position zero");

   // a new result needs a sample that was held the cycle before
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(item.valid))
      else $error("result without a sample behind it");

endmodule

`default_nettype wire
